FILE: rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants for the pulse sound channels
// Payload structs, control structs, register codes and the length table.
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int unsigned FRAME_W = 15;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W = 8;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_PATTERN_0 = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_PATTERN_1 = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_PATTERN_2 = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_PATTERN_3 = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_DIVIDE  = 3'd4;

	// Configuration reset values.
	localparam logic [7:0] DUTY_PATTERN_0_RST = 8'd64;
	localparam logic [7:0] DUTY_PATTERN_1_RST = 8'd96;
	localparam logic [7:0] DUTY_PATTERN_2_RST = 8'd120;
	localparam logic [7:0] DUTY_PATTERN_3_RST = 8'd159;
	localparam logic [3:0] SAMPLE_DIVIDE_RST  = 4'd10;

	// Channel register offsets within one channel.
	localparam logic [1:0] REG_CONTROL     = 2'd0;
	localparam logic [1:0] REG_SWEEP       = 2'd1;
	localparam logic [1:0] REG_PERIOD_LOW  = 2'd2;
	localparam logic [1:0] REG_PERIOD_HIGH = 2'd3;

	localparam logic [14:0] LENGTH_TICK_MID = 15'd14913;
	localparam logic [10:0] SHORT_PERIOD    = 11'd8;
	localparam logic [3:0]  DECAY_START     = 4'd15;

	typedef struct packed {
		logic       write_enable;
		logic [2:0] reg_index;
		logic [7:0] write_data;
	} psc_in_t;

	typedef struct packed {
		logic [7:0] mixed_sample;
		logic       sample_valid;
		logic       frame_end_flag;
		logic [3:0] level_one;
		logic [3:0] level_two;
	} psc_out_t;

	// Register write routed to one channel.
	typedef struct packed {
		logic       en;
		logic [1:0] offset;
		logic [7:0] data;
	} psc_wr_t;

	// Per-cycle timing decisions from the frame sequencer.
	typedef struct packed {
		logic odd;
		logic env_tick;
		logic len_tick;
		logic sample_due;
		logic frame_end;
	} psc_tick_t;

	function automatic logic [7:0] length_lookup(input logic [4:0] idx);
		logic [7:0] v;
		unique case (idx)
			5'd0:  v = 8'd10;
			5'd1:  v = 8'd254;
			5'd2:  v = 8'd20;
			5'd3:  v = 8'd2;
			5'd4:  v = 8'd40;
			5'd5:  v = 8'd4;
			5'd6:  v = 8'd80;
			5'd7:  v = 8'd6;
			5'd8:  v = 8'd160;
			5'd9:  v = 8'd8;
			5'd10: v = 8'd60;
			5'd11: v = 8'd10;
			5'd12: v = 8'd14;
			5'd13: v = 8'd12;
			5'd14: v = 8'd26;
			5'd15: v = 8'd14;
			5'd16: v = 8'd12;
			5'd17: v = 8'd16;
			5'd18: v = 8'd24;
			5'd19: v = 8'd18;
			5'd20: v = 8'd48;
			5'd21: v = 8'd20;
			5'd22: v = 8'd96;
			5'd23: v = 8'd22;
			5'd24: v = 8'd192;
			5'd25: v = 8'd24;
			5'd26: v = 8'd72;
			5'd27: v = 8'd26;
			5'd28: v = 8'd16;
			5'd29: v = 8'd28;
			5'd30: v = 8'd32;
			5'd31: v = 8'd30;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/psc_frame.sv
// ----------------------------------------------------------------------------
// psc_frame: frame cycle counter and sample divider
// Decides odd cycles, envelope and length ticks, the frame end, and when a sample is due.
// ----------------------------------------------------------------------------
module psc_frame #(
	parameter int unsigned FRAME_LENGTH = 29830
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  logic [3:0]            sample_divide,
	output psc_pkg::psc_tick_t    tick
);
	import psc_pkg::*;

	localparam logic [FRAME_W-1:0] LAST_CYCLE = FRAME_W'(FRAME_LENGTH);
	localparam logic [FRAME_W-1:0] ENV_CYCLE  = FRAME_W'(FRAME_LENGTH - 1);
	localparam logic [FRAME_W-1:0] END_CYCLE  = FRAME_W'(FRAME_LENGTH - 2);

	logic [FRAME_W-1:0] frame_cycle_q;
	logic [3:0]         sample_count_q;

	always_comb begin
		tick.odd        = frame_cycle_q[0];
		tick.env_tick   = frame_cycle_q[0] && (frame_cycle_q == ENV_CYCLE);
		tick.len_tick   = frame_cycle_q[0] &&
			((frame_cycle_q == ENV_CYCLE) || (frame_cycle_q == LENGTH_TICK_MID));
		tick.sample_due = frame_cycle_q[0] && (sample_count_q >= sample_divide);
		tick.frame_end  = (frame_cycle_q >= END_CYCLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cycle_q  <= '0;
			sample_count_q <= '0;
		end else if (step_en) begin
			if (frame_cycle_q >= LAST_CYCLE) begin
				frame_cycle_q <= '0;
			end else begin
				frame_cycle_q <= frame_cycle_q + 1'b1;
			end
			if (tick.odd) begin
				if (tick.sample_due) begin
					sample_count_q <= '0;
				end else begin
					sample_count_q <= sample_count_q + 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/psc_channel.sv
// ----------------------------------------------------------------------------
// psc_channel: one pulse channel
// Register writes, period timer, duty sequencer, envelope and length counter.
// ----------------------------------------------------------------------------
module psc_channel (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  psc_pkg::psc_wr_t    wr,
	input  psc_pkg::psc_tick_t  tick,
	input  logic [3:0][7:0]     duty_patterns,
	output logic [3:0]          level_next
);
	import psc_pkg::*;

	logic [1:0]  duty_select_q;
	logic        loop_flag_q;
	logic        constant_flag_q;
	logic [3:0]  volume_value_q;
	logic [3:0]  envelope_divider_q;
	logic [3:0]  decay_level_q;
	logic [10:0] period_reload_q;
	logic [10:0] period_count_q;
	logic [7:0]  length_count_q;
	logic [7:0]  low_byte_latch_q;
	logic        wave_bit_q;
	logic [2:0]  wave_step_q;
	logic [3:0]  channel_level_q;

	// Values after this cycle's register write.
	logic [1:0]  duty_w;
	logic        loop_w;
	logic        const_w;
	logic [3:0]  vol_w;
	logic [3:0]  envdiv_w;
	logic [3:0]  decay_w;
	logic [10:0] reload_w;
	logic [10:0] pcount_w;
	logic [7:0]  length_w;
	logic [7:0]  latch_w;

	// Values after the odd-cycle update.
	logic [3:0]  envdiv_n;
	logic [3:0]  decay_n;
	logic [10:0] pcount_n;
	logic [7:0]  length_n;
	logic        wave_bit_n;
	logic [2:0]  wave_step_n;

	always_comb begin
		duty_w   = duty_select_q;
		loop_w   = loop_flag_q;
		const_w  = constant_flag_q;
		vol_w    = volume_value_q;
		envdiv_w = envelope_divider_q;
		decay_w  = decay_level_q;
		reload_w = period_reload_q;
		pcount_w = period_count_q;
		length_w = length_count_q;
		latch_w  = low_byte_latch_q;
		if (wr.en) begin
			unique case (wr.offset)
				REG_CONTROL: begin
					duty_w   = wr.data[7:6];
					loop_w   = wr.data[5];
					const_w  = wr.data[4];
					vol_w    = wr.data[3:0];
					envdiv_w = wr.data[3:0];
				end
				REG_PERIOD_LOW: begin
					latch_w = wr.data;
				end
				REG_PERIOD_HIGH: begin
					reload_w = {wr.data[2:0], low_byte_latch_q};
					pcount_w = {wr.data[2:0], low_byte_latch_q};
					length_w = length_lookup(wr.data[7:3]);
					decay_w  = DECAY_START;
				end
				REG_SWEEP: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		envdiv_n    = envdiv_w;
		decay_n     = decay_w;
		pcount_n    = pcount_w;
		length_n    = length_w;
		wave_bit_n  = wave_bit_q;
		wave_step_n = wave_step_q;
		level_next  = channel_level_q;
		if (tick.odd) begin
			if (pcount_w != '0) begin
				pcount_n = pcount_w - 1'b1;
			end else begin
				pcount_n    = reload_w;
				wave_bit_n  = (reload_w >= SHORT_PERIOD) && duty_patterns[duty_w][wave_step_q];
				wave_step_n = wave_step_q - 1'b1;
			end

			// Level uses the decay and length values from before this cycle's ticks.
			if (wave_bit_n && (length_w != '0)) begin
				level_next = const_w ? vol_w : decay_w;
			end else begin
				level_next = '0;
			end

			if (tick.env_tick) begin
				if (envdiv_w == '0) begin
					envdiv_n = vol_w;
					if (loop_w || (decay_w != '0)) begin
						decay_n = decay_w - 1'b1;
					end
				end else begin
					envdiv_n = envdiv_w - 1'b1;
				end
			end

			if (tick.len_tick && (length_w != '0)) begin
				length_n = length_w - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_select_q      <= '0;
			loop_flag_q        <= 1'b0;
			constant_flag_q    <= 1'b0;
			volume_value_q     <= '0;
			envelope_divider_q <= '0;
			decay_level_q      <= '0;
			period_reload_q    <= '0;
			period_count_q     <= '0;
			length_count_q     <= '0;
			low_byte_latch_q   <= '0;
			wave_bit_q         <= 1'b0;
			wave_step_q        <= '0;
			channel_level_q    <= '0;
		end else if (step_en) begin
			duty_select_q      <= duty_w;
			loop_flag_q        <= loop_w;
			constant_flag_q    <= const_w;
			volume_value_q     <= vol_w;
			envelope_divider_q <= envdiv_n;
			decay_level_q      <= decay_n;
			period_reload_q    <= reload_w;
			period_count_q     <= pcount_n;
			length_count_q     <= length_n;
			low_byte_latch_q   <= latch_w;
			wave_bit_q         <= wave_bit_n;
			wave_step_q        <= wave_step_n;
			channel_level_q    <= level_next;
		end
	end

endmodule

FILE: rtl/pulse_sound_channels_with_frame_counter.sv
// A result passes through the input register, then the result register, before it can
// be transferred out.
// Throughput: one item per cycle unless a result waits on result_stall.
// The input register lets one more item enter while a finished result waits on result_stall.
// Reset: arst_n clears all channel state, counters and valid flags and restores the
// configuration registers to their default duty patterns and sample divider.
// ----------------------------------------------------------------------------
// pulse_sound_channels_with_frame_counter: two pulse channels with frame timing
// Top level: handshakes, configuration registers, mixer and result register.
// ----------------------------------------------------------------------------
module pulse_sound_channels_with_frame_counter #(
	parameter int unsigned FRAME_LENGTH = 29830
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  psc_pkg::psc_in_t                    item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output psc_pkg::psc_out_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [psc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [psc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import psc_pkg::*;

	// Configuration registers. Writes are expected only while the block is idle,
	// so the port is always ready.
	logic [3:0][7:0] duty_patterns_q;
	logic [3:0]      sample_divide_q;

	// Input register: holds one item until the step logic can move it on.
	psc_in_t item_s1;
	logic    valid_s1;

	// Result register.
	psc_out_t result_q;
	logic     result_valid_q;

	logic       s1_move;
	logic       step_en;
	psc_tick_t  tick;
	psc_wr_t    wr_one;
	psc_wr_t    wr_two;
	logic [3:0] level_one_n;
	logic [3:0] level_two_n;
	logic [4:0] level_sum;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_patterns_q[0] <= DUTY_PATTERN_0_RST;
			duty_patterns_q[1] <= DUTY_PATTERN_1_RST;
			duty_patterns_q[2] <= DUTY_PATTERN_2_RST;
			duty_patterns_q[3] <= DUTY_PATTERN_3_RST;
			sample_divide_q    <= SAMPLE_DIVIDE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DUTY_PATTERN_0: duty_patterns_q[0] <= cfg_data;
				CFG_DUTY_PATTERN_1: duty_patterns_q[1] <= cfg_data;
				CFG_DUTY_PATTERN_2: duty_patterns_q[2] <= cfg_data;
				CFG_DUTY_PATTERN_3: duty_patterns_q[3] <= cfg_data;
				CFG_SAMPLE_DIVIDE:  sample_divide_q    <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// The item in the input register moves on whenever the result register is
	// empty or its result is being transferred out this cycle. The input side
	// stalls only when the input register is full and cannot move.
	assign s1_move    = !result_valid_q || !result_stall;
	assign step_en    = valid_s1 && s1_move;
	assign item_stall = valid_s1 && !s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Route a register write to the channel that bit two of the index selects.
	always_comb begin
		wr_one.en     = item_s1.write_enable && !item_s1.reg_index[2];
		wr_one.offset = item_s1.reg_index[1:0];
		wr_one.data   = item_s1.write_data;
		wr_two.en     = item_s1.write_enable && item_s1.reg_index[2];
		wr_two.offset = item_s1.reg_index[1:0];
		wr_two.data   = item_s1.write_data;
	end

	psc_frame #(
		.FRAME_LENGTH(FRAME_LENGTH)
	) u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (step_en),
		.sample_divide (sample_divide_q),
		.tick          (tick)
	);

	psc_channel u_channel_one (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (step_en),
		.wr            (wr_one),
		.tick          (tick),
		.duty_patterns (duty_patterns_q),
		.level_next    (level_one_n)
	);

	psc_channel u_channel_two (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (step_en),
		.wr            (wr_two),
		.tick          (tick),
		.duty_patterns (duty_patterns_q),
		.level_next    (level_two_n)
	);

	// With a sample, the mix is eight times the level sum, which always fits in eight bits.
	assign level_sum = {1'b0, level_one_n} + {1'b0, level_two_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_move) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			result_q.mixed_sample   <= tick.sample_due ? {level_sum, 3'b000} : 8'd0;
			result_q.sample_valid   <= tick.sample_due;
			result_q.frame_end_flag <= tick.frame_end;
			result_q.level_one      <= level_one_n;
			result_q.level_two      <= level_two_n;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: rtl/psc_checker.sv
// ----------------------------------------------------------------------------
// psc_checker: port-level checks for the pulse sound channels
// Watches the top level's ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
module psc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_stall,
	input psc_pkg::psc_in_t                item,
	input logic                            result_valid,
	input logic                            result_stall,
	input psc_pkg::psc_out_t               result
);
	import psc_pkg::*;

	logic result_xfer;
	logic last_sample_q;

	assign result_xfer = result_valid && !result_stall;

	// Remembers whether the previous result transfer carried a sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_q <= 1'b0;
		end else if (result_xfer) begin
			last_sample_q <= result.sample_valid;
		end
	end

	// A stalled input item holds until it is taken.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("input item changed while stalled");

	// A stalled result holds until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// The mix is zero without a sample and eight times the level sum with one.
	a_mix_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.sample_valid ?
			(result.mixed_sample == {5'(result.level_one) + 5'(result.level_two), 3'b000}) :
			(result.mixed_sample == 8'd0)))
		else $error("mixed sample does not match channel levels");

	// Samples fall only on odd cycles, so two results in a row never both carry one.
	a_sample_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_xfer && result.sample_valid |-> !last_sample_q)
		else $error("samples on two consecutive results");

	// Reset empties the result register.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

endmodule

bind pulse_sound_channels_with_frame_counter psc_checker u_psc_checker (.*);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the two pulse sound channels
// Streams input items with optional channel register writes into the block,
// predicts every result word from an independent behavioral model of the
// channels and the frame sequencer, and compares each accepted result field by
// field. Duty patterns and the sample divider are changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import psc_pkg::*;

	// The frame length of the instance; the predictor uses the same value.
	localparam int unsigned FRAME_LEN = 29830;
	// Generous watchdog: the slowest correct run stays far below this.
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned CHUNK_ITEMS = 85;
	localparam int unsigned CHUNKS = 6;
	localparam int unsigned FINAL_ITEMS = 32;
	localparam logic CH_ONE = 1'b0;
	localparam logic CH_TWO = 1'b1;

	// ------------------------------------------------------------------------
	// Channel model and result scoreboard. Every input transfer advances the
	// model by one CPU cycle and queues the result word that cycle must give.
	// ------------------------------------------------------------------------
	class sound_scoreboard;
		int unsigned frame_len;
		logic [7:0]  len_table [32];
		logic [7:0]  duty_pat [4];
		logic [3:0]  divide;
		logic [14:0] frame_cycle;
		logic [3:0]  sample_count;
		logic [1:0]  duty_sel [2];
		logic        loop_on [2];
		logic        const_on [2];
		logic [3:0]  volume [2];
		logic [3:0]  env_div [2];
		logic [3:0]  decay [2];
		logic [3:0]  level [2];
		logic [10:0] reload [2];
		logic [10:0] count [2];
		logic [7:0]  length [2];
		logic [7:0]  low_latch [2];
		logic        wave_bit [2];
		logic [2:0]  wave_step [2];
		int unsigned results_seen;
		int unsigned error_count;
		psc_out_t    predicted_outputs [$];

		function new(int unsigned frame_length);
			frame_len = frame_length;
			len_table = '{8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
				8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
				8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
				8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30};
			duty_pat[0] = DUTY_PATTERN_0_RST;
			duty_pat[1] = DUTY_PATTERN_1_RST;
			duty_pat[2] = DUTY_PATTERN_2_RST;
			duty_pat[3] = DUTY_PATTERN_3_RST;
			divide = SAMPLE_DIVIDE_RST;
			frame_cycle = '0;
			sample_count = '0;
			for (int i = 0; i < 2; i++) begin
				duty_sel[i] = '0;
				loop_on[i] = 1'b0;
				const_on[i] = 1'b0;
				volume[i] = '0;
				env_div[i] = '0;
				decay[i] = '0;
				level[i] = '0;
				reload[i] = '0;
				count[i] = '0;
				length[i] = '0;
				low_latch[i] = '0;
				wave_bit[i] = 1'b0;
				wave_step[i] = '0;
			end
			results_seen = 0;
			error_count = 0;
		endfunction

		function void set_setting(logic [2:0] idx, logic [7:0] val);
			if (idx <= CFG_DUTY_PATTERN_3)
				duty_pat[idx[1:0]] = val;
			else if (idx == CFG_SAMPLE_DIVIDE)
				divide = val[3:0];
		endfunction

		function void step_channel(int i, logic env_tick, logic len_tick);
			if (count[i] != 0) begin
				count[i] = count[i] - 11'd1;
			end else begin
				count[i] = reload[i];
				wave_bit[i] = (reload[i] >= SHORT_PERIOD) ?
					duty_pat[duty_sel[i]][wave_step[i]] : 1'b0;
				wave_step[i] = wave_step[i] - 3'd1;
			end
			level[i] = (wave_bit[i] && length[i] != 0) ?
				(const_on[i] ? volume[i] : decay[i]) : 4'd0;
			if (env_tick) begin
				if (env_div[i] == 0) begin
					env_div[i] = volume[i];
					if (loop_on[i])
						decay[i] = decay[i] - 4'd1;
					else if (decay[i] != 0)
						decay[i] = decay[i] - 4'd1;
				end else begin
					env_div[i] = env_div[i] - 4'd1;
				end
			end
			if (len_tick && length[i] != 0)
				length[i] = length[i] - 8'd1;
		endfunction

		// One CPU cycle: the register write lands first, then the odd-cycle update.
		function void note_cycle(psc_in_t c);
			logic [14:0] fc;
			logic        env_tick;
			logic        len_tick;
			logic        ch;
			psc_out_t    o;
			fc = frame_cycle;
			env_tick = (fc == frame_len - 1);
			len_tick = env_tick || (fc == LENGTH_TICK_MID);
			o = '0;
			if (c.write_enable) begin
				ch = c.reg_index[2];
				case (c.reg_index[1:0])
					REG_CONTROL: begin
						duty_sel[ch] = c.write_data[7:6];
						loop_on[ch] = c.write_data[5];
						const_on[ch] = c.write_data[4];
						volume[ch] = c.write_data[3:0];
						env_div[ch] = c.write_data[3:0];
					end
					REG_PERIOD_LOW: begin
						low_latch[ch] = c.write_data;
					end
					REG_PERIOD_HIGH: begin
						reload[ch] = {c.write_data[2:0], low_latch[ch]};
						count[ch] = reload[ch];
						length[ch] = len_table[c.write_data[7:3]];
						decay[ch] = DECAY_START;
					end
					default: begin
					end
				endcase
			end
			if (fc[0]) begin
				step_channel(0, env_tick, len_tick);
				step_channel(1, env_tick, len_tick);
				if (sample_count >= divide) begin
					sample_count = '0;
					o.sample_valid = 1'b1;
					o.mixed_sample = 8'(level[0]) * 8'd8 + 8'(level[1]) * 8'd8;
				end else begin
					sample_count = sample_count + 4'd1;
				end
			end
			o.frame_end_flag = (fc >= frame_len - 2);
			o.level_one = level[0];
			o.level_two = level[1];
			predicted_outputs.push_back(o);
			if (fc >= frame_len)
				frame_cycle = '0;
			else
				frame_cycle = fc + 15'd1;
		endfunction

		task report(string msg);
			error_count++;
			$display("mismatch: %s", msg);
		endtask

		task check_output(psc_out_t r);
			psc_out_t e;
			if (predicted_outputs.size() == 0) begin
				report($sformatf("result %h arrived with nothing predicted", r));
				return;
			end
			e = predicted_outputs.pop_front();
			if (r.mixed_sample !== e.mixed_sample)
				report($sformatf("result %0d mixed_sample %0d, predicted %0d",
					results_seen, r.mixed_sample, e.mixed_sample));
			if (r.sample_valid !== e.sample_valid)
				report($sformatf("result %0d sample_valid %b, predicted %b",
					results_seen, r.sample_valid, e.sample_valid));
			if (r.frame_end_flag !== e.frame_end_flag)
				report($sformatf("result %0d frame_end_flag %b, predicted %b",
					results_seen, r.frame_end_flag, e.frame_end_flag));
			if (r.level_one !== e.level_one)
				report($sformatf("result %0d level_one %0d, predicted %0d",
					results_seen, r.level_one, e.level_one));
			if (r.level_two !== e.level_two)
				report($sformatf("result %0d level_two %0d, predicted %0d",
					results_seen, r.level_two, e.level_two));
			results_seen++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	psc_in_t item;
	logic result_valid;
	logic result_stall;
	psc_out_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sound_scoreboard sb;
	// When clear, neither side inserts gaps or stalls.
	bit idle_on;
	int unsigned items_sent;
	int unsigned cycle_count;

	pulse_sound_channels_with_frame_counter #(
		.FRAME_LENGTH(FRAME_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Both channels are observed at the clock edge, before any of this edge's
	// updates land, so a transfer is seen exactly when the block takes it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_cycle(item);
			if (result_valid && !result_stall)
				sb.check_output(result);
		end
	end

	// The result side inserts random stall bursts while idling is on.
	initial begin
		int unsigned hold;
		hold = 0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold != 0)
				hold--;
			else if (idle_on && $urandom_range(0, 5) == 0)
				hold = $urandom_range(1, 4);
			result_stall <= (hold != 0);
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL pulse_sound_channels_with_frame_counter");
		$finish;
	end

	function automatic psc_in_t make_write(logic ch, logic [1:0] offset, logic [7:0] data);
		psc_in_t c;
		c.write_enable = 1'b1;
		c.reg_index = {ch, offset};
		c.write_data = data;
		return c;
	endfunction

	// A write with random data. Period writes lean toward short periods so the
	// waveforms step often.
	function automatic psc_in_t channel_write(logic ch, logic [1:0] offset);
		psc_in_t c;
		c = make_write(ch, offset, 8'($urandom_range(0, 255)));
		if (offset == REG_PERIOD_LOW && $urandom_range(0, 3) != 0)
			c.write_data = 8'($urandom_range(0, 40));
		if (offset == REG_PERIOD_HIGH && $urandom_range(0, 3) != 0)
			c.write_data[2:0] = 3'd0;
		return c;
	endfunction

	// A cycle that writes with the given chance in percent. Index and data are
	// random even when nothing is written, since the block must ignore them.
	function automatic psc_in_t random_cycle(int unsigned write_pct);
		psc_in_t c;
		c = channel_write(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
		c.write_enable = ($urandom_range(0, 99) < write_pct);
		return c;
	endfunction

	// Presents one cycle and returns at the edge where it is transferred.
	// Valid stays high into the next item unless a gap is drawn.
	task automatic send_item(psc_in_t c);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= c;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// The usual driver sequence for one channel: control, an occasional sweep
	// write, period low, period high, then some silent cycles. Now and then
	// one step is dropped to give a broken sequence.
	task automatic program_channel(logic ch);
		logic [1:0] steps [3];
		bit         broken;
		int unsigned skip;
		steps = '{REG_CONTROL, REG_PERIOD_LOW, REG_PERIOD_HIGH};
		broken = ($urandom_range(0, 4) == 0);
		skip = $urandom_range(0, 2);
		for (int s = 0; s < 3; s++) begin
			if (!(broken && s == skip))
				send_item(channel_write(ch, steps[s]));
			if (s == 0 && $urandom_range(0, 3) == 0)
				send_item(channel_write(ch, REG_SWEEP));
		end
		repeat ($urandom_range(4, 40))
			send_item(random_cycle(0));
	endtask

	// Stops sending and waits until every predicted result has come out, so
	// the block is idle and settings may change. The first edge lets the last
	// transfer reach the scoreboard.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.predicted_outputs.size() != 0)
			@(posedge clk);
	endtask

	task automatic push_setting(logic [2:0] idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_setting(idx, val);
	endtask

	// Writes all four duty patterns and the divider back to back. Valid is
	// lowered once, after the last transfer.
	task automatic apply_settings(logic [3:0][7:0] pats, logic [7:0] divide_val,
			bit poke_unused);
		for (int i = 0; i < 4; i++)
			push_setting(CFG_DUTY_PATTERN_0 + 3'(i), pats[i]);
		push_setting(CFG_SAMPLE_DIVIDE, divide_val);
		// An index past the last register must change nothing.
		if (poke_unused)
			push_setting(CFG_SAMPLE_DIVIDE + 3'($urandom_range(1, 3)),
				8'($urandom_range(0, 255)));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [3:0][7:0] pats;
		logic [7:0]      divide_val;
		int unsigned     chunk_end;
		psc_in_t         c;

		sb = new(FRAME_LEN);
		idle_on = 1'b1;
		items_sent = 0;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cycles under the reset duty patterns. Channel one gets a
		// constant full volume at the shortest period that still sounds.
		send_item(make_write(CH_ONE, REG_CONTROL, 8'hBF));
		send_item(make_write(CH_ONE, REG_SWEEP, 8'hFF));
		send_item(make_write(CH_ONE, REG_PERIOD_LOW, 8'h08));
		send_item(make_write(CH_ONE, REG_PERIOD_HIGH, 8'h08));
		// Channel two one below that period, where the wave bit is forced low.
		send_item(make_write(CH_TWO, REG_CONTROL, 8'hDF));
		send_item(make_write(CH_TWO, REG_PERIOD_LOW, 8'h07));
		send_item(make_write(CH_TWO, REG_PERIOD_HIGH, 8'h00));
		// A cycle without a write, carrying an index and data all ones.
		c = make_write(CH_TWO, REG_PERIOD_HIGH, 8'hFF);
		c.write_enable = 1'b0;
		send_item(c);
		// Decay envelope with no loop, then the longest period and the
		// largest length index.
		send_item(make_write(CH_TWO, REG_CONTROL, 8'h00));
		send_item(make_write(CH_TWO, REG_PERIOD_LOW, 8'hFF));
		send_item(make_write(CH_TWO, REG_PERIOD_HIGH, 8'hFF));
		send_item(make_write(CH_TWO, REG_PERIOD_HIGH, 8'h00));
		// A zero period, then the length entry of two.
		send_item(make_write(CH_TWO, REG_PERIOD_LOW, 8'h00));
		send_item(make_write(CH_TWO, REG_PERIOD_HIGH, 8'hF8));
		send_item(make_write(CH_TWO, REG_PERIOD_HIGH, 8'h18));
		// Looping decay on channel one, with the latched low byte reused.
		send_item(make_write(CH_ONE, REG_CONTROL, 8'h2F));
		send_item(make_write(CH_ONE, REG_PERIOD_HIGH, 8'h09));
		repeat (8)
			send_item(random_cycle(0));

		// Random phases, each under its own settings. The first two take the
		// extremes of the patterns and of the divider; one phase runs with no
		// idling at all. The drain before each phase also holds the sender
		// back until every result is out.
		for (int k = 0; k < CHUNKS; k++) begin
			drain();
			case (k)
				0: begin
					pats = {4{8'hFF}};
					divide_val = 8'h00;
				end
				1: begin
					pats = '0;
					divide_val = 8'h0F;
				end
				2: begin
					pats = $urandom;
					divide_val = 8'hFF;
				end
				default: begin
					pats = $urandom;
					divide_val = 8'($urandom_range(0, 255));
				end
			endcase
			apply_settings(pats, divide_val, k == 1);
			idle_on = (k != 2);
			chunk_end = items_sent + CHUNK_ITEMS;
			while (items_sent < chunk_end) begin
				if ($urandom_range(0, 4) == 0)
					send_item(random_cycle(60));
				else
					program_channel(1'($urandom_range(0, 1)));
			end
		end

		// Final stretch without idling on either side, with sparse writes to
		// keep the channels changing.
		drain();
		apply_settings($urandom, 8'($urandom_range(0, 15)), 1'b0);
		idle_on = 1'b0;
		repeat (FINAL_ITEMS)
			send_item(random_cycle(10));

		drain();
		// Keep clocking so a stray extra result would still be caught.
		repeat (4) @(posedge clk);
		if (sb.error_count == 0)
			$display("PASS pulse_sound_channels_with_frame_counter");
		else
			$display("FAIL pulse_sound_channels_with_frame_counter");
		$finish;
	end

endmodule
